// ===== rtl/dsdpk_pkg.sv =====
// dsdpk_pkg: shared constants, widths and helpers for the dsd planar-to-interleaved packer
// depends on nothing; imported by the packer top level and its testbench
package dsdpk_pkg;

  // planar block length in bytes per channel
  localparam int BLOCK_BYTES = 4096;

  // left store address and block position widths
  localparam int ADDR_W = $clog2(BLOCK_BYTES);
  localparam int POS_W  = $clog2(2 * BLOCK_BYTES);

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_PAD_HALF           = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_BLOCK_WORDS = 1'd1;

  // dsd silence pattern
  localparam logic [7:0] DSD_SILENCE = 8'h69;

  typedef logic [7:0] byte_t;

  // lsb-first to msb-first byte reversal
  function automatic byte_t flip_bits(input byte_t v);
    byte_t x;
    x = ((v & 8'haa) >> 1) | ((v & 8'h55) << 1);
    x = ((x & 8'hcc) >> 2) | ((x & 8'h33) << 2);
    x = {x[3:0], x[7:4]};
    return x;
  endfunction

endpackage

// ===== rtl/dsd_planar_to_interleaved_packer_unit.sv =====
// dsd_planar_to_interleaved_packer_unit: planar dsf stereo bytes in, interleaved chunks out
// depends on dsdpk_pkg (constants, byte reversal)
//
// Usage:
//   s_axis carries one request per planar byte: tdata is the byte, tuser is the
//   command (0 = audio byte, 1 = end-of-stream flush). A block of BLOCK_BYTES left
//   bytes is written into the left store, then each pair of right bytes yields a
//   chunk on m_axis: pad zeros, two reversed left bytes, pad zeros, two reversed
//   right bytes. m_axis tuser flags the byte that closes a sample block, tlast the
//   last byte caused by one input request. A flush fills the open sample block
//   with 0x69 and restarts the planar block.
//   The left store has one write and one read port. The right byte that
//   completes a pair passes stage b and the emitter job slot before its first
//   chunk byte enters the output register. Left bytes go in one per cycle while
//   stage b holds no waiting request. The single chunk emitter sends each chunk
//   (4 + 2*pad bytes; pad is pad_half, a value of three counts as two) and flush
//   silence via the one-byte output register, one byte per cycle when not stalled.
//   Reset (rst, synchronous): position, counters, pipeline and output clear;
//   pad_half = 0, sample_block_words = 8. The left store is not cleared.
//   When m_axis stalls the output holds, the emitter and then the input stall;
//   configuration is written through cfg_we/cfg_addr/cfg_wdata while idle.
module dsd_planar_to_interleaved_packer_unit (
  input  logic                             clk,
  input  logic                             rst,
  // input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,  // [7:0] data_byte
  input  logic                             s_axis_tuser,  // [0] command
  // output stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [7:0]                       m_axis_tdata,  // [7:0] out_byte
  output logic                             m_axis_tuser,  // [0] block_end
  output logic                             m_axis_tlast,
  // configuration writes
  input  logic                             cfg_we,
  input  logic [dsdpk_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [dsdpk_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import dsdpk_pkg::*;

  localparam logic [POS_W-1:0] BLOCK_POS = POS_W'(BLOCK_BYTES);
  localparam logic [POS_W-1:0] LAST_POS  = POS_W'(2 * BLOCK_BYTES - 1);

  // stage b request kinds
  localparam logic [1:0] K_HOLD  = 2'd0;
  localparam logic [1:0] K_CHUNK = 2'd1;
  localparam logic [1:0] K_FLUSH = 2'd2;

  // configuration registers
  logic [1:0] pad_half;
  logic [4:0] sample_block_words;

  // left store
  byte_t mem [BLOCK_BYTES];
  byte_t rdata;

  // stage a state
  logic [POS_W-1:0]  pos;
  byte_t             held_right;

  // stage b
  logic       b_valid;
  logic [1:0] b_kind;
  byte_t      b_r0;
  byte_t      b_r1;
  byte_t      held_left;

  // chunk emitter
  logic       j_valid;
  logic       j_flush;
  logic [2:0] j_idx;
  byte_t      j_l0, j_l1, j_r0, j_r1;
  logic [5:0] fill;

  // output register
  logic       o_valid;
  byte_t      o_byte;
  logic       o_end;
  logic       o_last;

  // effective configuration
  logic [1:0] pad_eff;
  logic [4:0] words_eff;
  logic [6:0] size_bytes;

  always_comb begin
    pad_eff = (pad_half == 2'd3) ? 2'd2 : pad_half;
    if (sample_block_words == 5'd0) begin
      words_eff = 5'd1;
    end else if (sample_block_words > 5'd16) begin
      words_eff = 5'd16;
    end else begin
      words_eff = sample_block_words;
    end
    size_bytes = {words_eff, 2'b00};
  end

  // stage a decode
  logic             accept;
  logic             is_left;
  logic [POS_W-1:0] r_full;
  logic [ADDR_W-1:0] r;

  assign accept  = s_axis_tvalid && s_axis_tready;
  assign is_left = pos < BLOCK_POS;
  assign r_full  = pos - BLOCK_POS;
  assign r       = r_full[ADDR_W-1:0];

  // emitter control
  logic       out_free;
  logic       flush_empty;
  logic       fire;
  logic       last;
  logic       j_done;
  logic       j_free;
  logic       b_go;
  logic [2:0] p3;
  logic [6:0] fill_inc;
  logic       wrap;
  byte_t      emit_byte;

  always_comb begin
    p3          = {1'b0, pad_eff};
    out_free    = !o_valid || m_axis_tready;
    flush_empty = j_flush && (fill == 6'd0);
    fire        = j_valid && !flush_empty && out_free;
    fill_inc    = {1'b0, fill} + 7'd1;
    wrap        = fill_inc >= size_bytes;
    if (j_flush) begin
      last      = wrap;
      emit_byte = DSD_SILENCE;
    end else begin
      last = (j_idx == (p3 << 1) + 3'd3);
      priority if (j_idx < p3) begin
        emit_byte = 8'h00;
      end else if (j_idx == p3) begin
        emit_byte = flip_bits(j_l0);
      end else if (j_idx == p3 + 3'd1) begin
        emit_byte = flip_bits(j_l1);
      end else if (j_idx == (p3 << 1) + 3'd2) begin
        emit_byte = flip_bits(j_r0);
      end else if (j_idx == (p3 << 1) + 3'd3) begin
        emit_byte = flip_bits(j_r1);
      end else begin
        emit_byte = 8'h00;
      end
    end
    j_done = j_valid && (flush_empty || (fire && last));
    j_free = !j_valid || j_done;
    b_go   = b_valid && ((b_kind == K_HOLD) || j_free);
  end

  assign s_axis_tready = !b_valid || b_go;

  // left store write and read
  always_ff @(posedge clk) begin
    if (accept && !s_axis_tuser && is_left) begin
      mem[pos[ADDR_W-1:0]] <= s_axis_tdata;
    end
    if (accept && !s_axis_tuser && !is_left) begin
      rdata <= mem[r];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pad_half           <= 2'd0;
      sample_block_words <= 5'd8;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_PAD_HALF:           pad_half <= cfg_wdata[1:0];
        CFG_SAMPLE_BLOCK_WORDS: sample_block_words <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // block position and pending right byte
  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      held_right <= 8'h00;
    end else if (accept) begin
      if (s_axis_tuser) begin
        pos        <= '0;
        held_right <= 8'h00;
      end else if (is_left) begin
        pos <= pos + POS_W'(1);
      end else begin
        if (!r[0]) begin
          held_right <= s_axis_tdata;
        end
        pos <= (pos == LAST_POS) ? '0 : pos + POS_W'(1);
      end
    end
  end

  // stage b: waits for the left store read
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (accept) begin
      b_valid <= s_axis_tuser || !is_left;
    end else if (b_go) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (s_axis_tuser) begin
        b_kind <= K_FLUSH;
      end else if (!r[0]) begin
        b_kind <= K_HOLD;
      end else begin
        b_kind <= K_CHUNK;
      end
      b_r0 <= held_right;
      b_r1 <= s_axis_tdata;
    end
    if (b_go && (b_kind == K_HOLD)) begin
      held_left <= rdata;
    end
  end

  // chunk emitter job slot
  always_ff @(posedge clk) begin
    if (rst) begin
      j_valid <= 1'b0;
    end else if (b_go && (b_kind != K_HOLD)) begin
      j_valid <= 1'b1;
    end else if (j_done) begin
      j_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go && (b_kind != K_HOLD)) begin
      j_flush <= (b_kind == K_FLUSH);
      j_idx   <= 3'd0;
      j_l0    <= held_left;
      j_l1    <= rdata;
      j_r0    <= b_r0;
      j_r1    <= b_r1;
    end else if (fire) begin
      j_idx <= j_idx + 3'd1;
    end
  end

  // sample block fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 6'd0;
    end else if (cfg_we && (cfg_addr == CFG_SAMPLE_BLOCK_WORDS)) begin
      fill <= 6'd0;
    end else if (fire) begin
      fill <= wrap ? 6'd0 : fill_inc[5:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (fire) begin
      o_valid <= 1'b1;
    end else if (m_axis_tready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      o_byte <= emit_byte;
      o_end  <= wrap;
      o_last <= last;
    end
  end

  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = o_byte;
  assign m_axis_tuser  = o_end;
  assign m_axis_tlast  = o_last;

endmodule

// ===== rtl/dsdpk_port_checker.sv =====
// dsdpk_port_checker: port-level checks on the packer handshakes
// depends only on the top level's ports; bound to dsd_planar_to_interleaved_packer_unit
module dsdpk_port_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tuser,
  input logic       m_axis_tlast
);

  // reset empties the output register
  a_reset_clears_out: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // reset leaves the input ready
  a_reset_in_ready: assert property (@(posedge clk) rst |=> s_axis_tready)
    else $error("input not ready after reset");

  // a stalled output byte holds
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled output changed");

  // a run continues without a gap once its bytes are being taken
  a_run_no_gap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("gap inside an output run");

endmodule

bind dsd_planar_to_interleaved_packer_unit dsdpk_port_checker u_dsdpk_port_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/sv/dsd_planar_to_interleaved_packer_unit_tb.sv =====
// dsd_planar_to_interleaved_packer_unit_tb: self-checking bench for the planar-to-interleaved packer
// feeds planar left/right blocks, flushes and register writes, predicts and checks every output byte
// depends on dsdpk_pkg and dsd_planar_to_interleaved_packer_unit
module dsd_planar_to_interleaved_packer_unit_tb;
  import dsdpk_pkg::*;

  localparam logic CMD_AUDIO = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;
  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_HOLD = 600;
  localparam int RUN_LIMIT = 30_000_000;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic  cmd;
    byte_t data;
  } planar_req_t;

  typedef struct packed {
    byte_t data;
    logic  block_end;
    logic  last;
  } chunk_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;  // [7:0] data_byte
  logic s_axis_tuser = 1'b0;         // [0] command
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;          // [7:0] out_byte
  logic m_axis_tuser;                // [0] block_end
  logic m_axis_tlast;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  dsd_planar_to_interleaved_packer_unit dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #(RUN_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // shared bench state
  idle_mode_t idle_mode = IDLE_NONE;
  planar_req_t planar_pending[$];
  planar_req_t next_req;
  int queued_count = 0;
  int accepted_count = 0;
  int errors = 0;
  logic in_taken = 1'b0;
  chunk_byte_t want;
  int rx_hold_asked = 0;
  int rx_hold_served = 0;
  int rx_hold_count = 0;

  // predicted block state
  byte_t left_plane [BLOCK_BYTES];
  int unsigned plane_pos = 0;
  byte_t right_first = 8'h00;
  int unsigned frame_fill = 0;
  logic [1:0] pad_bytes = 2'd0;
  logic [4:0] frame_words = 5'd8;
  chunk_byte_t chunk_bytes_due[$];

  function automatic bit idle_draw(input idle_mode_t own);
    if (idle_mode == own) return $urandom_range(99) < 46;
    if (idle_mode == IDLE_BOTH) return $urandom_range(99) < 29;
    return 1'b0;
  endfunction

  // lsb-first to msb-first
  function automatic byte_t reverse_byte(input byte_t v);
    byte_t r;
    int i;
    for (i = 0; i < 8; i++) r[i] = v[7-i];
    return r;
  endfunction

  // sample block length in bytes, word count clamped to 1..16
  function automatic int unsigned frame_size();
    if (frame_words == 0) return 4;
    if (frame_words > 16) return 64;
    return 4 * frame_words;
  endfunction

  function automatic void emit_byte(input byte_t b);
    chunk_byte_t c;
    frame_fill++;
    c.data = b;
    c.block_end = (frame_fill >= frame_size());
    c.last = 1'b0;
    if (c.block_end) frame_fill = 0;
    chunk_bytes_due.push_back(c);
  endfunction

  // one accepted request: update the planar state and queue the bytes it causes
  function automatic void pack_planar_byte(input logic cmd, input byte_t data);
    int unsigned due_before;
    int unsigned r;
    int unsigned pad;
    int unsigned j;
    chunk_byte_t tail;
    due_before = chunk_bytes_due.size();
    pad = (pad_bytes > 2) ? 2 : pad_bytes;
    if (cmd == CMD_FLUSH) begin
      // close the open sample block with silence, restart the planar block
      while (frame_fill != 0) emit_byte(DSD_SILENCE);
      plane_pos = 0;
      right_first = 8'h00;
    end else if (plane_pos < BLOCK_BYTES) begin
      left_plane[plane_pos] = data;
      plane_pos++;
    end else begin
      r = plane_pos - BLOCK_BYTES;
      if (r % 2 == 0) begin
        right_first = data;
      end else if (r < BLOCK_BYTES) begin
        for (j = 0; j < pad; j++) emit_byte(8'h00);
        emit_byte(reverse_byte(left_plane[r-1]));
        emit_byte(reverse_byte(left_plane[r]));
        for (j = 0; j < pad; j++) emit_byte(8'h00);
        emit_byte(reverse_byte(right_first));
        emit_byte(reverse_byte(data));
      end
      plane_pos++;
      if (plane_pos >= 2 * BLOCK_BYTES) plane_pos = 0;
    end
    if (chunk_bytes_due.size() > due_before) begin
      tail = chunk_bytes_due.pop_back();
      tail.last = 1'b1;
      chunk_bytes_due.push_back(tail);
    end
  endfunction

  task automatic report(input string what, input logic [7:0] exp_v, input logic [7:0] act_v);
    errors++;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_v, act_v);
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (planar_pending.size() != 0 && !idle_draw(IDLE_SEND)) begin
        next_req = planar_pending.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= next_req.data;
        s_axis_tuser <= next_req.cmd;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output ready, with random stalls and the long hold-off
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (rx_hold_count != 0) begin
      rx_hold_count--;
      m_axis_tready <= 1'b0;
    end else if (rx_hold_served != rx_hold_asked) begin
      rx_hold_served++;
      rx_hold_count = LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !idle_draw(IDLE_RECV);
    end
  end

  // monitor: predict on accepted requests, check accepted output bytes
  always @(posedge clk) begin
    if (rst) begin
      in_taken = 1'b0;
    end else begin
      in_taken = s_axis_tvalid && s_axis_tready;
      if (in_taken) begin
        pack_planar_byte(s_axis_tuser, s_axis_tdata);
        accepted_count++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (chunk_bytes_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected output byte, expected none, actual %h",
                   $time, m_axis_tdata);
        end else begin
          want = chunk_bytes_due.pop_front();
          if (m_axis_tdata !== want.data) report("out_byte", want.data, m_axis_tdata);
          if (m_axis_tuser !== want.block_end)
            report("block_end", {7'b0, want.block_end}, {7'b0, m_axis_tuser});
          if (m_axis_tlast !== want.last)
            report("run_last", {7'b0, want.last}, {7'b0, m_axis_tlast});
        end
      end
    end
  end

  task automatic offer(input logic cmd, input byte_t data);
    planar_req_t q;
    q.cmd = cmd;
    q.data = data;
    planar_pending.push_back(q);
    queued_count++;
  endtask

  task automatic offer_left_block();
    int k;
    for (k = 0; k < BLOCK_BYTES; k++)
      offer(CMD_AUDIO, (k == 0) ? 8'h00 : (k == 1) ? 8'hff : byte_t'($urandom_range(255)));
  endtask

  task automatic offer_right_bytes(input int n);
    int k;
    for (k = 0; k < n; k++) offer(CMD_AUDIO, byte_t'($urandom_range(255)));
  endtask

  // register write while idle; predictor follows
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_PAD_HALF) begin
      pad_bytes = val[1:0];
    end else begin
      frame_words = val;
      frame_fill = 0;
    end
  endtask

  // all requests taken and all bytes out, then let trailing work settle
  task automatic wait_idle();
    while (accepted_count != queued_count || chunk_bytes_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // stimulus
  initial begin
    int ph;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // flush on an empty sample block, a partial left block cut by a flush
    offer(CMD_FLUSH, 8'hff);
    offer_right_bytes(20);
    offer(CMD_FLUSH, 8'h00);
    // one full left block, then right pairs with extreme bytes
    offer_left_block();
    offer(CMD_AUDIO, 8'h00);
    offer(CMD_AUDIO, 8'hff);
    offer(CMD_AUDIO, 8'h01);
    offer(CMD_AUDIO, 8'h80);
    offer(CMD_AUDIO, 8'h0f);
    offer(CMD_AUDIO, 8'hf0);
    offer(CMD_AUDIO, 8'h55);
    offer(CMD_AUDIO, 8'haa);
    wait_idle();

    // pad three saturates, zero words means one word
    idle_mode = IDLE_SEND;
    write_reg(CFG_PAD_HALF, 5'b10111);
    write_reg(CFG_SAMPLE_BLOCK_WORDS, 5'd0);
    offer_right_bytes(60);
    wait_idle();

    // oversize word count, long output hold-off while requests keep coming
    idle_mode = IDLE_RECV;
    write_reg(CFG_PAD_HALF, 5'b01001);
    write_reg(CFG_SAMPLE_BLOCK_WORDS, 5'd17);
    rx_hold_asked++;
    offer_right_bytes(120);
    wait_idle();

    // largest block, left with an open sample block before the next word write
    idle_mode = IDLE_BOTH;
    write_reg(CFG_PAD_HALF, 5'b01010);
    write_reg(CFG_SAMPLE_BLOCK_WORDS, 5'd16);
    offer_right_bytes(10);
    wait_idle();
    write_reg(CFG_SAMPLE_BLOCK_WORDS, 5'd1);

    // random phases over settings and idle patterns, whole right pairs only
    for (ph = 0; ph < 8; ph++) begin
      idle_mode = idle_mode_t'(ph % 4);
      write_reg(CFG_PAD_HALF, 5'($urandom_range(31)));
      if ($urandom_range(3) != 0 || ph == 0)
        write_reg(CFG_SAMPLE_BLOCK_WORDS, (ph == 0) ? 5'd31 : 5'($urandom_range(31)));
      offer_right_bytes(2 * int'($urandom_range(10, 25)));
      wait_idle();
    end

    // pending right byte dropped by the flush, silence fills the block
    offer_right_bytes(3);
    offer(CMD_FLUSH, 8'h3c);
    wait_idle();

    if (errors == 0 && chunk_bytes_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
